### rtl/core/shpd_pkg.sv
// Shared constants, types and the CORDIC arctangent table.
`timescale 1ns / 1ps
package shpd_pkg;

  localparam int HALF_CYCLE_SAMPLES = 1024;
  localparam int MAX_RISE           = 512;
  localparam int SKEW_STEPS         = 32;

  localparam int SKEW_W = 5;
  localparam int POS_W  = 10;
  localparam int OP_W   = 2;
  localparam int OUT_W  = 16;

  localparam int D_STEPS   = SKEW_STEPS - 1;
  localparam int RISE_STEP = MAX_RISE - 1;
  localparam int FULL_SPAN = HALF_CYCLE_SAMPLES * D_STEPS;

  localparam int RATIO_W  = 15;   // num and den
  localparam int FRAC_W   = 16;   // u, Q0.16
  localparam int DIV_BITS = FRAC_W;

  localparam int CORDIC_ITERS = 24;
  localparam int CW           = 34; // CORDIC datapath, signed Q2.30 with headroom
  localparam int MAG_W        = 31;
  localparam int PROD_W       = 46;

  localparam logic [30:0] Q30_HALF_PI  = 31'd1686629713;
  localparam logic [30:0] Q30_GAIN_INV = 31'd652032874;
  localparam logic [30:0] Q30_ONE      = 31'd1073741824;
  localparam logic [14:0] FULL_SCALE   = 15'd32767;

  localparam logic [OP_W-1:0] OP_SINE = 2'd0;
  localparam logic [OP_W-1:0] OP_TRI  = 2'd1;
  localparam logic [OP_W-1:0] OP_SAW  = 2'd2;

  typedef struct packed {
    logic            vld;
    logic            rise;
    logic [OP_W-1:0] op;
  } tag_t;

  function automatic logic [CW-1:0] atan_q30(input int i);
    logic [CW-1:0] v;
    case (i)
      0:  v = 34'h03243F6A8;
      1:  v = 34'h01DAC6705;
      2:  v = 34'h00FADBAFC;
      3:  v = 34'h007F56EA6;
      4:  v = 34'h003FEAB76;
      5:  v = 34'h001FFD55B;
      6:  v = 34'h000FFFAAA;
      7:  v = 34'h0007FFF55;
      8:  v = 34'h0003FFFEA;
      9:  v = 34'h0001FFFFD;
      10: v = 34'h0000FFFFF;
      11: v = 34'h00007FFFF;
      12: v = 34'h00003FFFF;
      13: v = 34'h00001FFFF;
      14: v = 34'h00000FFFF;
      15: v = 34'h000007FFF;
      16: v = 34'h000003FFF;
      17: v = 34'h000001FFF;
      18: v = 34'h000000FFF;
      19: v = 34'h0000007FF;
      20: v = 34'h0000003FF;
      21: v = 34'h0000001FF;
      22: v = 34'h0000000FF;
      23: v = 34'h00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/shpd_prep.sv
// Ratio set-up stage: rise test, numerator and denominator.
`timescale 1ns / 1ps
module shpd_prep (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [shpd_pkg::SKEW_W-1:0]  skew,
  input  logic [shpd_pkg::POS_W-1:0]   pos,
  input  logic [shpd_pkg::OP_W-1:0]    op,
  output shpd_pkg::tag_t               tag_r,
  output logic [shpd_pkg::RATIO_W-1:0] num_r,
  output logic [shpd_pkg::RATIO_W-1:0] den_r
);
  import shpd_pkg::*;

  logic [RATIO_W-1:0] rn, sd;
  logic               rise;
  tag_t               tag_nxt;
  logic [RATIO_W-1:0] num_nxt, den_nxt;

  always_comb begin
    rn      = RATIO_W'(D_STEPS) + RATIO_W'(skew) * RATIO_W'(RISE_STEP);
    sd      = RATIO_W'(pos) * RATIO_W'(D_STEPS);
    rise    = sd < rn;
    num_nxt = rise ? sd : sd - rn;
    den_nxt = rise ? rn : RATIO_W'(FULL_SPAN) - rn;
    tag_nxt = '{vld: in_vld, rise: rise, op: op};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else if (adv) begin
      tag_r.vld <= tag_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r.rise <= tag_nxt.rise;
      tag_r.op   <= tag_nxt.op;
      num_r      <= num_nxt;
      den_r      <= den_nxt;
    end
  end
endmodule

### rtl/core/shpd_div.sv
// Restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
module shpd_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  shpd_pkg::tag_t               tag_i,
  input  logic [shpd_pkg::RATIO_W-1:0] num_i,
  input  logic [shpd_pkg::RATIO_W-1:0] den_i,
  output shpd_pkg::tag_t               tag_o,
  output logic [shpd_pkg::FRAC_W-1:0]  u_o
);
  import shpd_pkg::*;

  tag_t               tag_s [0:DIV_BITS];
  logic [RATIO_W-1:0] rem_s [0:DIV_BITS];
  logic [RATIO_W-1:0] den_s [0:DIV_BITS];
  logic [FRAC_W-1:0]  q_s   [0:DIV_BITS];

  assign tag_s[0] = tag_i;
  assign rem_s[0] = num_i;
  assign den_s[0] = den_i;
  assign q_s[0]   = '0;

  for (genvar g = 0; g < DIV_BITS; g++) begin : g_stage
    logic [RATIO_W:0]   sh;
    logic               ge;
    tag_t               tag_r;
    logic [RATIO_W-1:0] rem_r, den_r;
    logic [FRAC_W-1:0]  q_r;

    assign sh = {rem_s[g], 1'b0};
    assign ge = sh >= {1'b0, den_s[g]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r.vld <= 1'b0;
      end else if (adv) begin
        tag_r.vld <= tag_s[g].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tag_r.rise <= tag_s[g].rise;
        tag_r.op   <= tag_s[g].op;
        rem_r      <= ge ? RATIO_W'(sh - {1'b0, den_s[g]}) : RATIO_W'(sh);
        den_r      <= den_s[g];
        q_r        <= {q_s[g][FRAC_W-2:0], ge};
      end
    end

    assign tag_s[g+1] = tag_r;
    assign rem_s[g+1] = rem_r;
    assign den_s[g+1] = den_r;
    assign q_s[g+1]   = q_r;
  end

  assign tag_o = tag_s[DIV_BITS];
  assign u_o   = q_s[DIV_BITS];
endmodule

### rtl/core/shpd_cordic.sv
// Angle scaling stage then one CORDIC rotation per stage.
`timescale 1ns / 1ps
module shpd_cordic (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  shpd_pkg::tag_t              tag_i,
  input  logic [shpd_pkg::FRAC_W-1:0] u_i,
  output shpd_pkg::tag_t              tag_o,
  output logic [shpd_pkg::FRAC_W-1:0] u_o,
  output logic signed [shpd_pkg::CW-1:0] x_o,
  output logic signed [shpd_pkg::CW-1:0] y_o
);
  import shpd_pkg::*;

  tag_t                 tag_s [0:CORDIC_ITERS];
  logic [FRAC_W-1:0]    u_s   [0:CORDIC_ITERS];
  logic signed [CW-1:0] x_s   [0:CORDIC_ITERS];
  logic signed [CW-1:0] y_s   [0:CORDIC_ITERS];
  logic signed [CW-1:0] z_s   [0:CORDIC_ITERS];

  logic [FRAC_W+31-1:0] ang_prod;
  tag_t                 tag0_r;
  logic [FRAC_W-1:0]    u0_r;
  logic signed [CW-1:0] z0_r;

  assign ang_prod = (FRAC_W+31)'(u_i) * (FRAC_W+31)'(Q30_HALF_PI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r.vld <= 1'b0;
    end else if (adv) begin
      tag0_r.vld <= tag_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag0_r.rise <= tag_i.rise;
      tag0_r.op   <= tag_i.op;
      u0_r        <= u_i;
      z0_r        <= CW'(ang_prod >> FRAC_W);
    end
  end

  assign tag_s[0] = tag0_r;
  assign u_s[0]   = u0_r;
  assign x_s[0]   = CW'(Q30_GAIN_INV);
  assign y_s[0]   = '0;
  assign z_s[0]   = z0_r;

  for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    logic                 pos;
    tag_t                 tag_r;
    logic [FRAC_W-1:0]    u_r;
    logic signed [CW-1:0] x_r, y_r, z_r;

    assign dx  = y_s[g] >>> g;
    assign dy  = x_s[g] >>> g;
    assign pos = !z_s[g][CW-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r.vld <= 1'b0;
      end else if (adv) begin
        tag_r.vld <= tag_s[g].vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tag_r.rise <= tag_s[g].rise;
        tag_r.op   <= tag_s[g].op;
        u_r        <= u_s[g];
        x_r        <= pos ? x_s[g] - dx : x_s[g] + dx;
        y_r        <= pos ? y_s[g] + dy : y_s[g] - dy;
        z_r        <= pos ? z_s[g] - signed'(atan_q30(g)) : z_s[g] + signed'(atan_q30(g));
      end
    end

    assign tag_s[g+1] = tag_r;
    assign u_s[g+1]   = u_r;
    assign x_s[g+1]   = x_r;
    assign y_s[g+1]   = y_r;
    assign z_s[g+1]   = z_r;
  end

  assign tag_o = tag_s[CORDIC_ITERS];
  assign u_o   = u_s[CORDIC_ITERS];
  assign x_o   = x_s[CORDIC_ITERS];
  assign y_o   = y_s[CORDIC_ITERS];
endmodule

### rtl/core/shpd_scale.sv
// Waveform select, scale by full range, round half to even, apply sign.
`timescale 1ns / 1ps
module shpd_scale (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  shpd_pkg::tag_t                 tag_i,
  input  logic [shpd_pkg::FRAC_W-1:0]    u_i,
  input  logic signed [shpd_pkg::CW-1:0] x_i,
  input  logic signed [shpd_pkg::CW-1:0] y_i,
  output logic                           vld_r,
  output logic [shpd_pkg::OUT_W-1:0]     val_r
);
  import shpd_pkg::*;

  logic signed [CW-1:0] comp;
  logic [MAG_W-1:0]     mag;
  logic [FRAC_W:0]      u_inv;
  logic                 sel30_nxt, neg_nxt, zero_nxt;

  logic                 pvld_r, sel30_r, neg_r, zero_r;
  logic [PROD_W-1:0]    prod_r;

  logic [OUT_W-1:0]     q, res;
  logic                 up;

  // first stage: magnitude and product
  always_comb begin
    comp      = tag_i.rise ? y_i : x_i;
    u_inv     = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(u_i);
    sel30_nxt = 1'b0;
    neg_nxt   = 1'b0;
    zero_nxt  = 1'b0;
    mag       = '0;
    case (tag_i.op)
      OP_SINE: begin
        sel30_nxt = 1'b1;
        if (comp[CW-1])                     mag = '0;
        else if (comp > CW'(Q30_ONE))       mag = Q30_ONE;
        else                                mag = MAG_W'(comp);
      end
      OP_TRI: begin
        mag = tag_i.rise ? MAG_W'(u_i) : MAG_W'(u_inv);
      end
      OP_SAW: begin
        mag     = tag_i.rise ? MAG_W'(u_inv) : MAG_W'(u_i);
        neg_nxt = tag_i.rise;
      end
      default: begin
        zero_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      vld_r  <= 1'b0;
    end else if (adv) begin
      pvld_r <= tag_i.vld;
      vld_r  <= pvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= PROD_W'(mag) * PROD_W'(FULL_SCALE);
      sel30_r <= sel30_nxt;
      neg_r   <= neg_nxt;
      zero_r  <= zero_nxt;
    end
  end

  // second stage: round half to even
  always_comb begin
    if (sel30_r) begin
      q  = OUT_W'(prod_r >> 30);
      up = prod_r[29] && ((prod_r[28:0] != '0) || q[0]);
    end else begin
      q  = OUT_W'(prod_r >> 16);
      up = prod_r[15] && ((prod_r[14:0] != '0) || q[0]);
    end
    res = q + OUT_W'(up);
    if (neg_r)  res = OUT_W'(-res);
    if (zero_r) res = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r <= res;
    end
  end
endmodule

### rtl/core/skewed_half_cycle_wave_sample.sv
// Top level: skewed half-cycle wave sample pipeline.
`timescale 1ns / 1ps
//
// Channel | Ports                                              | Dir
// input   | in_valid, in_ready, in_skew_index, in_sample_position, in_opcode | in
// result  | out_valid, out_ready, out_sample_value             | out
//
// One item enters per clock while the result side is not stalled; the stages
// are 1 ratio set-up, 16 divider, 1 angle, 24 CORDIC and 2 scale/round.
// The 16-stage bit-per-stage divider and the 24-stage CORDIC set the depth.
// Reset (synchronous, active low) clears the valid bits only.
// A stall on the result side freezes every stage together; nothing is
// dropped or repeated, and in_ready follows the output stage's readiness.
module skewed_half_cycle_wave_sample (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [shpd_pkg::SKEW_W-1:0] in_skew_index,
  input  logic [shpd_pkg::POS_W-1:0]  in_sample_position,
  input  logic [shpd_pkg::OP_W-1:0]   in_opcode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [shpd_pkg::OUT_W-1:0] out_sample_value
);
  import shpd_pkg::*;

  // whole pipe moves whenever the output register is empty or being taken
  logic adv;

  tag_t                 prep_tag, div_tag, cor_tag;
  logic [RATIO_W-1:0]   prep_num, prep_den;
  logic [FRAC_W-1:0]    div_u, cor_u;
  logic signed [CW-1:0] cor_x, cor_y;
  logic [OUT_W-1:0]     val;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  shpd_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_valid),
    .skew   (in_skew_index),
    .pos    (in_sample_position),
    .op     (in_opcode),
    .tag_r  (prep_tag),
    .num_r  (prep_num),
    .den_r  (prep_den)
  );

  // u = (num << 16) / den, num < den always
  shpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .tag_i (prep_tag),
    .num_i (prep_num),
    .den_i (prep_den),
    .tag_o (div_tag),
    .u_o   (div_u)
  );

  shpd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .tag_i (div_tag),
    .u_i   (div_u),
    .tag_o (cor_tag),
    .u_o   (cor_u),
    .x_o   (cor_x),
    .y_o   (cor_y)
  );

  // last register of the scaler is the output register
  shpd_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .tag_i (cor_tag),
    .u_i   (cor_u),
    .x_i   (cor_x),
    .y_i   (cor_y),
    .vld_r (out_valid),
    .val_r (val)
  );

  assign out_sample_value = signed'(val);
endmodule

### tb/sv/skewed_half_cycle_wave_sample_tb.sv
// Testbench for the skewed half-cycle wave sample pipeline: predicted samples vs. DUT.
`timescale 1ns / 1ps
module skewed_half_cycle_wave_sample_tb;
  import shpd_pkg::*;

  localparam int LATENCY    = 44;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  // opcode with no waveform behind it; the block answers zero
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic [SKEW_W-1:0] skew;
    logic [POS_W-1:0]  pos;
    logic [OP_W-1:0]   op;
  } wave_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SKEW_W-1:0] in_skew_index = '0;
  logic [POS_W-1:0] in_sample_position = '0;
  logic [OP_W-1:0] in_opcode = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_sample_value;

  wave_req_t pending_reqs[$];
  logic signed [OUT_W-1:0] expected_samples[$];
  int mismatches = 0;
  bit stim_done = 1'b0;
  bit sender_pause = 1'b0;   // hold the sender until everything has drained
  bit rx_hold_req = 1'b0;    // ask the receiver for a long hold-off
  bit quiet_phase = 1'b0;    // stretch with no random idling on either side
  int hold_count = 0;
  int idle_cycles = 0;

  skewed_half_cycle_wave_sample uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Arithmetic shift with floor, for 64-bit signed values
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  // round(mag * 32767 / 2^sh), ties to even
  function automatic longint scale_to_full(longint unsigned mag, int sh);
    longint unsigned p, q, r, half;
    p = mag * 32767;
    q = p >> sh;
    r = p & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (r > half || (r == half && q[0])) q++;
    return longint'(q);
  endfunction

  function automatic longint cordic_sincos(longint unsigned u16, bit want_cos);
    longint atans[CORDIC_ITERS] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    longint z, x, y, dx, dy;
    z = longint'((u16 * 64'd1686629713) >> 16);
    x = 652032874;
    y = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atans[i];
      end else begin
        x += dx; y -= dy; z += atans[i];
      end
    end
    return want_cos ? x : y;
  endfunction

  function automatic logic signed [OUT_W-1:0] predict_sample(wave_req_t r);
    longint unsigned t, s, rn, num, den, u16;
    longint v, res;
    bit rise;
    t = r.skew;
    s = r.pos;
    if (t > D_STEPS) t = D_STEPS;
    if (s > HALF_CYCLE_SAMPLES - 1) s = HALF_CYCLE_SAMPLES - 1;
    rn = D_STEPS + t * RISE_STEP;
    rise = (s * D_STEPS < rn);
    if (rise) begin
      num = s * D_STEPS; den = rn;
    end else begin
      num = s * D_STEPS - rn; den = FULL_SPAN - rn;
    end
    u16 = (num << 16) / den;
    res = 0;
    case (r.op)
      OP_SINE: begin
        v = cordic_sincos(u16, !rise);
        if (v < 0) v = 0;
        if (v > 64'd1073741824) v = 64'd1073741824;
        res = scale_to_full(longint'(v), 30);
      end
      OP_TRI: res = scale_to_full(rise ? u16 : 65536 - u16, 16);
      OP_SAW: res = rise ? -scale_to_full(65536 - u16, 16) : scale_to_full(u16, 16);
      default: res = 0;
    endcase
    return res[OUT_W-1:0];
  endfunction

  function automatic bit take_gap();
    return !quiet_phase && ($urandom_range(0, 99) < 16);
  endfunction

  // Driver: offers the head of the queue; valid holds until transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_samples.push_back(predict_sample(
          '{skew: in_skew_index, pos: in_sample_position, op: in_opcode}));
        void'(pending_reqs.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && !sender_pause && !take_gap()) begin
          in_valid <= 1'b1;
          in_skew_index <= pending_reqs[0].skew;
          in_sample_position <= pending_reqs[0].pos;
          in_opcode <= pending_reqs[0].op;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls, a long counted hold-off on request, result checks
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none, actual %0d", $time,
                   out_sample_value);
          mismatches++;
        end else begin
          if (out_sample_value !== expected_samples[0]) begin
            $display("%0t: sample_value mismatch, expected %0d, actual %0d", $time,
                     expected_samples[0], out_sample_value);
            mismatches++;
          end
          void'(expected_samples.pop_front());
        end
      end
      if (rx_hold_req && hold_count == 0) hold_count = HOLD_CYCLES;
      if (hold_count > 0) begin
        hold_count--;
        if (hold_count == 0) rx_hold_req = 1'b0;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !take_gap();
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || hold_count > 0)
      idle_cycles <= 0;
    else if (pending_reqs.size() > 0 || expected_samples.size() > 0 || !stim_done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic wave_req_t rand_req();
    wave_req_t r;
    r.skew = SKEW_W'($urandom_range(0, 31));
    r.pos  = POS_W'($urandom_range(0, 1023));
    r.op   = ($urandom_range(0, 19) == 0) ? OP_UNDEF : OP_W'($urandom_range(0, 2));
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    logic [OP_W-1:0] op_list[4] = '{OP_SINE, OP_TRI, OP_SAW, OP_UNDEF};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, each waveform, undefined opcode, full-length
    // rise, rise/fall boundary
    foreach (op_list[k]) begin
      pending_reqs.push_back('{skew: 5'd0, pos: 10'd0, op: op_list[k]});
      pending_reqs.push_back('{skew: 5'd31, pos: 10'd1023, op: op_list[k]});
      pending_reqs.push_back('{skew: 5'd0, pos: 10'd1, op: op_list[k]});
      pending_reqs.push_back('{skew: 5'd31, pos: 10'd511, op: op_list[k]});
      pending_reqs.push_back('{skew: 5'd31, pos: 10'd512, op: op_list[k]});
    end
    pending_reqs.push_back('{skew: 5'd15, pos: 10'd700, op: OP_SINE});

    // Sender offers nothing more until all expected results have come
    wait_drained();
    repeat (2) @(posedge clk);

    // Long receiver hold-off while the sender keeps offering: pipeline fills
    quiet_phase = 1'b1;
    for (int i = 0; i < 100; i++) pending_reqs.push_back(rand_req());
    rx_hold_req = 1'b1;
    wait_drained();
    sender_pause = 1'b1;
    repeat (20) @(posedge clk);
    sender_pause = 1'b0;
    quiet_phase = 1'b0;

    // Random bulk, with one stretch free of idling
    for (int i = 0; i < 950; i++) begin
      if (i == 400) begin
        wait_drained();
        quiet_phase = 1'b1;
      end
      if (i == 600) begin
        wait_drained();
        quiet_phase = 1'b0;
      end
      pending_reqs.push_back(rand_req());
    end
    stim_done = 1'b1;
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/shpd_pkg.sv
rtl/core/shpd_prep.sv
rtl/core/shpd_div.sv
rtl/core/shpd_cordic.sv
rtl/core/shpd_scale.sv
rtl/core/skewed_half_cycle_wave_sample.sv
tb/sv/skewed_half_cycle_wave_sample_tb.sv
